### hdl/tsrtc_pkg.sv
// ----------------------------------------------------------------------------
// tsrtc_pkg: shared types and tables for the timestamp text converter
// Payload structs, status codes and the calendar lookup tables.
// ----------------------------------------------------------------------------
package tsrtc_pkg;

	localparam int unsigned TS_LEN      = 14;
	localparam int unsigned DATE_CHARS  = 8;
	localparam int unsigned TIME_CHARS  = 6;
	localparam logic [6:0]  YEAR_CENTURY = 7'd20;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_NON_DIGIT = 3'd2,
		ST_RANGE     = 3'd3,
		ST_DAY       = 3'd4
	} status_t;

	typedef struct packed {
		logic [63:0] date_text;
		logic [47:0] time_text;
		logic [3:0]  char_count;
	} stamp_t;

	typedef struct packed {
		status_t    status;
		logic [6:0] year_offset;
		logic [3:0] month_num;
		logic [4:0] day_num;
		logic [4:0] hour_num;
		logic [5:0] minute_num;
		logic [5:0] second_num;
		logic [2:0] weekday;
	} rtc_fields_t;

	// days in month, February as non-leap
	function automatic logic [4:0] month_days(input logic [6:0] mo);
		logic [4:0] d;
		case (mo)
			7'd2: d = 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	// Sakamoto month offsets
	function automatic logic [2:0] month_key(input logic [6:0] mo);
		logic [2:0] k;
		case (mo)
			7'd1:  k = 3'd0;
			7'd2:  k = 3'd3;
			7'd3:  k = 3'd2;
			7'd4:  k = 3'd5;
			7'd5:  k = 3'd0;
			7'd6:  k = 3'd3;
			7'd7:  k = 3'd5;
			7'd8:  k = 3'd1;
			7'd9:  k = 3'd4;
			7'd10: k = 3'd6;
			7'd11: k = 3'd2;
			7'd12: k = 3'd4;
			default: k = 3'd0;
		endcase
		return k;
	endfunction

endpackage

### hdl/timestamp_text_to_rtc_fields_core.sv
// ----------------------------------------------------------------------------
// timestamp_text_to_rtc_fields_core: ASCII YYYYMMDDhhmmss to RTC fields
// Checks length, digits, ranges and month length, and finds the weekday.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive stamp (date word, time word, char count) and pulse start.
//   A transfer happens on any edge with start high and busy low; busy never
//   rises, so a new timestamp may be offered on every cycle.
//   Output: done is high for exactly one cycle with result valid alongside.
//   The receiver has no back-pressure and must take result in that cycle.
// Pipeline and throughput
//   Three register stages: decode and digit check, range check and weekday
//   partial sum, then month-length check and mod-7 into the output register.
//   done is the valid bit of the output register; one item per cycle.
// Status
//   0 ok, 1 too short, 2 non-digit, 3 field out of range, 4 day beyond
//   month. The first failing check wins and every other field reads zero.
// Reset
//   arst_n clears the stage valid bits, so nothing is emitted until new
//   timestamps arrive; the data registers are not reset.
// ----------------------------------------------------------------------------
module timestamp_text_to_rtc_fields_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  tsrtc_pkg::stamp_t      stamp,
	output logic                   done,
	output tsrtc_pkg::rtc_fields_t result
);

	// ------------------------------------------------------------ stage 1
	logic [7:0] chr      [tsrtc_pkg::TS_LEN];
	logic [3:0] dig      [tsrtc_pkg::TS_LEN];
	logic [tsrtc_pkg::TS_LEN-1:0] is_dig;

	logic       valid_s1;
	logic       short_s1;
	logic       nondig_s1;
	logic [6:0] cent_s1, yl_s1, mo_s1, da_s1, hh_s1, mi_s1, se_s1;

	function automatic logic [6:0] pair10(input logic [3:0] hi, input logic [3:0] lo);
		return 7'(hi) * 7'd10 + 7'(lo);
	endfunction

	always_comb begin
		for (int i = 0; i < tsrtc_pkg::DATE_CHARS; i++) begin
			chr[i] = stamp.date_text[63 - 8*i -: 8];
		end
		for (int i = 0; i < tsrtc_pkg::TIME_CHARS; i++) begin
			chr[tsrtc_pkg::DATE_CHARS + i] = stamp.time_text[47 - 8*i -: 8];
		end
		for (int i = 0; i < tsrtc_pkg::TS_LEN; i++) begin
			is_dig[i] = (chr[i] >= 8'h30) && (chr[i] <= 8'h39);
			dig[i]    = chr[i][3:0];
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		short_s1  <= stamp.char_count < 4'(tsrtc_pkg::TS_LEN);
		nondig_s1 <= !(&is_dig);
		cent_s1   <= pair10(dig[0],  dig[1]);
		yl_s1     <= pair10(dig[2],  dig[3]);
		mo_s1     <= pair10(dig[4],  dig[5]);
		da_s1     <= pair10(dig[6],  dig[7]);
		hh_s1     <= pair10(dig[8],  dig[9]);
		mi_s1     <= pair10(dig[10], dig[11]);
		se_s1     <= pair10(dig[12], dig[13]);
	end

	// ------------------------------------------------------------ stage 2
	logic       range_bad;
	logic [4:0] dim;
	logic [6:0] kk;
	logic [7:0] wsum;

	logic                valid_s2;
	tsrtc_pkg::status_t  status_s2;
	logic [4:0]          dim_s2;
	logic [7:0]          wsum_s2;
	logic [6:0]          yl_s2, mo_s2, da_s2, hh_s2, mi_s2, se_s2;

	always_comb begin
		range_bad = (cent_s1 != tsrtc_pkg::YEAR_CENTURY) ||
			(mo_s1 < 7'd1) || (mo_s1 > 7'd12) ||
			(da_s1 < 7'd1) || (da_s1 > 7'd31) ||
			(hh_s1 > 7'd23) || (mi_s1 > 7'd59) || (se_s1 > 7'd59);
		// 2000 is a multiple of 400, so inside the century leap is just yl % 4
		dim = tsrtc_pkg::month_days(mo_s1);
		if (mo_s1 == 7'd2 && yl_s1[1:0] == 2'b00) begin
			dim = 5'd29;
		end
		// k = year-2000 (less one for Jan/Feb), biased by 4 to stay positive;
		// 2485 and the bias of four reduce to +2 mod 7
		kk   = yl_s1 + 7'd4 - ((mo_s1 < 7'd3) ? 7'd1 : 7'd0);
		wsum = 8'(kk) + 8'(kk[6:2]) + 8'(tsrtc_pkg::month_key(mo_s1))
			+ 8'(da_s1) + 8'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (short_s1) begin
			status_s2 <= tsrtc_pkg::ST_SHORT;
		end else if (nondig_s1) begin
			status_s2 <= tsrtc_pkg::ST_NON_DIGIT;
		end else if (range_bad) begin
			status_s2 <= tsrtc_pkg::ST_RANGE;
		end else begin
			status_s2 <= tsrtc_pkg::ST_OK;
		end
		dim_s2  <= dim;
		wsum_s2 <= wsum;
		yl_s2   <= yl_s1;
		mo_s2   <= mo_s1;
		da_s2   <= da_s1;
		hh_s2   <= hh_s1;
		mi_s2   <= mi_s1;
		se_s2   <= se_s1;
	end

	// ------------------------------------------------------------ stage 3
	function automatic logic [2:0] mod7(input logic [7:0] s);
		logic [6:0] a;
		logic [3:0] b;
		a = 7'(s[7:6]) + 7'(s[5:0]);
		b = 4'(a[6:3]) + 4'(a[2:0]);
		if (b >= 4'd7) b = b - 4'd7;
		if (b >= 4'd7) b = b - 4'd7;
		return b[2:0];
	endfunction

	tsrtc_pkg::status_t    status_fin;
	logic [2:0]            dow;
	tsrtc_pkg::rtc_fields_t res_d;

	logic                   valid_s3;
	tsrtc_pkg::rtc_fields_t result_s3;

	always_comb begin
		status_fin = status_s2;
		if (status_s2 == tsrtc_pkg::ST_OK && da_s2 > 7'(dim_s2)) begin
			status_fin = tsrtc_pkg::ST_DAY;
		end
		dow   = mod7(wsum_s2);
		res_d = '0;
		res_d.status = status_fin;
		if (status_fin == tsrtc_pkg::ST_OK) begin
			res_d.year_offset = yl_s2;
			res_d.month_num   = mo_s2[3:0];
			res_d.day_num     = da_s2[4:0];
			res_d.hour_num    = hh_s2[4:0];
			res_d.minute_num  = mi_s2[5:0];
			res_d.second_num  = se_s2[5:0];
			res_d.weekday     = (dow == 3'd0) ? 3'd7 : dow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_s3 <= res_d;
	end

	assign done   = valid_s3;
	assign result = result_s3;

	// ------------------------------------------------------------ checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(arst_n, 2) && $past(arst_n, 3))
		|-> (done == $past(start, 3)))
		else $error("done does not follow start by three cycles");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != tsrtc_pkg::ST_OK)
		|-> (result.year_offset == '0 && result.month_num == '0 &&
			result.day_num == '0 && result.hour_num == '0 &&
			result.minute_num == '0 && result.second_num == '0 &&
			result.weekday == '0))
		else $error("error result carries non-zero fields");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == tsrtc_pkg::ST_OK)
		|-> (result.weekday != 3'd0 && result.month_num != 4'd0 &&
			result.day_num != 5'd0 && result.month_num <= 4'd12))
		else $error("good result with invalid date fields");

endmodule
